// ----- rtl/core/p2sa_pkg.sv -----
// shared types, codes and constants of the aligned power-of-two slot allocator
// no dependencies
package p2sa_pkg;

	localparam int MAX_SLOTS   = 32;
	localparam int SLOT_W      = $clog2(MAX_SLOTS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int MARK_W      = 3;
	localparam int STACK_DEPTH = 6;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int MAX_MOVES   = 63;
	localparam int REC_DEPTH   = 64;
	localparam int REC_IDX_W   = $clog2(REC_DEPTH);

	localparam logic [MARK_W-1:0] MARK_FREE = 3'd7;
	localparam logic [MARK_W-1:0] MARK_RESV = 3'd6;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic REC_MOVE  = 1'b0;
	localparam logic REC_FINAL = 1'b1;

	localparam logic CFG_CHUNK_SLOTS = 1'b0;
	localparam logic CFG_MOVE_REPORT = 1'b1;

	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_BAD_SIZE    = 3'd1;
	localparam logic [2:0] STAT_FULL        = 3'd2;
	localparam logic [2:0] STAT_BAD_OFFSET  = 3'd3;
	localparam logic [2:0] STAT_NOT_ALLOC   = 3'd4;
	localparam logic [2:0] STAT_NOT_START   = 3'd5;
	localparam logic [2:0] STAT_DEFRAG_FAIL = 3'd6;

	typedef struct packed {
		logic [SLOT_W-1:0] from;
		logic [SLOT_W-1:0] to;
		logic [4:0]        slots;
	} move_rec_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} buf_ctl_t;

	typedef struct packed {
		logic [SLOT_W-1:0] base;
		logic [2:0]        wexp;
		logic [2:0]        sexp;
		logic [SLOT_W-1:0] o;
	} frame_t;

	// exponent of a power of two
	function automatic logic [2:0] exp_of(input logic [CNT_W-1:0] v);
		logic [2:0] e;
		e = 3'd0;
		for (int i = 0; i < CNT_W; i++) begin
			if (v[i]) e = 3'(i);
		end
		return e;
	endfunction

	function automatic logic [CNT_W-1:0] mask_of(input logic [2:0] e);
		return (CNT_W'(1) << e) - CNT_W'(1);
	endfunction

endpackage

// ----- rtl/core/p2sa_move_buf.sv -----
// move record queue: holds the moves of one allocation until it is known to succeed
// depends on p2sa_pkg
module p2sa_move_buf
	import p2sa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  buf_ctl_t  ctl,
	input  move_rec_t wr_rec,
	output logic      empty,
	output move_rec_t rd_rec
);

	move_rec_t             rec_mem [REC_DEPTH];
	logic [REC_IDX_W-1:0]  wr_ptr_q;
	logic [REC_IDX_W-1:0]  rd_ptr_q;
	move_rec_t             rd_rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (ctl.clear) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (ctl.push) wr_ptr_q <= wr_ptr_q + REC_IDX_W'(1);
			if (ctl.pop) rd_ptr_q <= rd_ptr_q + REC_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) rec_mem[wr_ptr_q] <= wr_rec;
		if (ctl.pop) rd_rec_q <= rec_mem[rd_ptr_q];
	end

	// never more than MAX_MOVES entries, so equal pointers mean empty
	assign empty  = (wr_ptr_q == rd_ptr_q);
	assign rd_rec = rd_rec_q;

endmodule

// ----- rtl/core/pow2_slot_allocator_defrag.sv -----
// Aligned power-of-two slot allocator with defragmentation.
// Request channel (req_valid/req_stall): req_type 0 allocates piece_slots slots,
// aligned to their size; req_type 1 frees the piece starting at free_offset.
// One request is worked on at a time; req_stall is high while it runs.
// Record channel (rec_valid/rec_stall): zero or more move records (record_kind 0),
// then exactly one final response (record_kind 1, last 1) per request.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 chunk_slots, which
// also frees every slot, 1 move_report_enable. Taken only while idle.
// Operation: all marks sit in one 32-entry memory with a registered read, and
// sweeps visit one slot per cycle. A free checks the start mark, then rewrites
// the piece slot by slot. An allocation first snapshots the marks, then scans for
// an empty window; on a miss each defrag level adds a window scan, a reserve pass,
// a probe of each slot position and, for each move, a copy and a release of the
// piece plus the nested scans. A failed defrag adds a restore pass. Moves are
// queued and only sent once the allocation succeeds, one record at a time.
// Reset: all slots free, chunk_slots 32, move reports on. No clearing pass:
// per-slot valid bits make unwritten slots read as free.
// A stalled receiver holds the output register and the sequencer waits on it.
// depends on p2sa_pkg, p2sa_move_buf
module pow2_slot_allocator_defrag
	import p2sa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              req_type,
	input  logic [CNT_W-1:0]  piece_slots,
	input  logic [SLOT_W-1:0] free_offset,
	output logic              rec_valid,
	input  logic              rec_stall,
	output logic              record_kind,
	output logic [2:0]        status,
	output logic [SLOT_W-1:0] alloc_offset,
	output logic [SLOT_W-1:0] move_from,
	output logic [SLOT_W-1:0] move_to,
	output logic [4:0]        move_slots,
	output logic [CNT_W-1:0]  free_slots_left,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [CNT_W-1:0]  cfg_data
);

	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_FREE_CHK   = 4'd1;
	localparam logic [3:0] ST_FILL       = 4'd2;
	localparam logic [3:0] ST_SNAP       = 4'd3;
	localparam logic [3:0] ST_SCAN       = 4'd4;
	localparam logic [3:0] ST_RESV       = 4'd5;
	localparam logic [3:0] ST_D_RD       = 4'd6;
	localparam logic [3:0] ST_D_CHK      = 4'd7;
	localparam logic [3:0] ST_MOVE       = 4'd8;
	localparam logic [3:0] ST_MOVE2      = 4'd9;
	localparam logic [3:0] ST_D_NEXT     = 4'd10;
	localparam logic [3:0] ST_ALLOC_FIN  = 4'd11;
	localparam logic [3:0] ST_RESTORE    = 4'd12;
	localparam logic [3:0] ST_FLUSH_RD   = 4'd13;
	localparam logic [3:0] ST_FLUSH_WAIT = 4'd14;
	localparam logic [3:0] ST_RESP       = 4'd15;

	localparam logic SCAN_EMPTY   = 1'b0;
	localparam logic SCAN_EMPTIER = 1'b1;

	// marks memory: low half current mark, high half snapshot
	logic [2*MARK_W-1:0] marks_mem [MAX_SLOTS];
	logic [2*MARK_W-1:0] mem_rd_q;
	logic                rd_ok_q;
	logic [MAX_SLOTS-1:0] valid_q;

	logic [3:0]          state_q;
	logic [CNT_W-1:0]    chunk_q;
	logic                report_en_q;
	logic [CNT_W-1:0]    free_cnt_q;

	logic [CNT_W-1:0]    piece_q;
	logic [2:0]          piece_exp_q;
	logic [SLOT_W-1:0]   off_q;
	logic [2:0]          status_q;
	logic [SLOT_W-1:0]   aoff_q;
	logic [CNT_W-1:0]    move_cnt_q;

	logic [CNT_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    lim_q;
	logic                pv_s1;
	logic [SLOT_W-1:0]   pa_s1;

	logic                scan_mode_q;
	logic [2:0]          scan_wexp_q;
	logic                win_ok_q;
	logic [CNT_W-1:0]    win_cnt_q;
	logic [CNT_W-1:0]    best_q;
	logic [SLOT_W-1:0]   best_at_q;

	logic [SLOT_W-1:0]   fill_at_q;
	logic [CNT_W-1:0]    fill_left_q;
	logic [MARK_W-1:0]   fill_mark_q;
	logic [3:0]          fill_next_q;

	frame_t              defrag_stack_q [STACK_DEPTH];
	logic [SLOT_W-1:0]   cur_base_q;
	logic [2:0]          cur_wexp_q;
	logic [2:0]          cur_sexp_q;
	logic [SLOT_W-1:0]   cur_o_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                in_defrag_q;
	logic [SLOT_W-1:0]   dst_q;

	logic                rec_valid_q;
	logic                record_kind_q;
	logic [2:0]          rec_status_q;
	logic [SLOT_W-1:0]   alloc_offset_q;
	logic [SLOT_W-1:0]   move_from_q;
	logic [SLOT_W-1:0]   move_to_q;
	logic [4:0]          move_slots_q;
	logic [CNT_W-1:0]    free_left_q;
	logic                last_q;

	logic                req_acc;
	logic                cfg_acc;
	logic                out_free;
	logic                sweep_st;
	logic                issue;
	logic                sweep_done;
	logic [SLOT_W-1:0]   raddr;
	logic [MARK_W-1:0]   cur_mark;
	logic [MARK_W-1:0]   sav_mark;
	logic [SLOT_W-1:0]   wm;
	logic                first_w;
	logic                last_w;
	logic                is_free;
	logic                acc_ok;
	logic [CNT_W-1:0]    acc_cnt;
	logic [SLOT_W-1:0]   win_base;
	logic                scan_found;
	logic [2:0]          call_wexp;
	logic [DEPTH_W-1:0]  call_depth;
	logic                call_fail;
	logic [CNT_W-1:0]    s_slots;
	logic [CNT_W-1:0]    o_next;
	logic [CNT_W-1:0]    win_end;
	logic                piece_bad;
	logic [CNT_W-1:0]    cfg_chunk;
	logic [CNT_W-1:0]    free_size;
	logic [CNT_W:0]      free_sum;

	logic                we_cur;
	logic                we_sav;
	logic                set_v;
	logic [SLOT_W-1:0]   waddr;
	logic [MARK_W-1:0]   wcur;

	buf_ctl_t            buf_ctl;
	move_rec_t           buf_wr;
	move_rec_t           buf_rd;
	logic                buf_empty;

	assign cfg_ready = (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE) || cfg_valid;
	assign req_acc   = req_valid && !req_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !rec_valid_q || !rec_stall;

	assign cur_mark = rd_ok_q ? mem_rd_q[MARK_W-1:0] : MARK_FREE;
	assign sav_mark = rd_ok_q ? mem_rd_q[2*MARK_W-1:MARK_W] : MARK_FREE;

	assign sweep_st   = (state_q == ST_SNAP) || (state_q == ST_SCAN) ||
	                    (state_q == ST_RESV) || (state_q == ST_RESTORE);
	assign issue      = sweep_st && (ptr_q < lim_q);
	assign sweep_done = !(ptr_q < lim_q) && !pv_s1;

	always_comb begin
		case (state_q)
			ST_IDLE: raddr = free_offset;
			ST_D_RD: raddr = cur_o_q;
			default: raddr = ptr_q[SLOT_W-1:0];
		endcase
	end

	// window accumulation of the scan stage
	assign wm       = SLOT_W'(mask_of(scan_wexp_q));
	assign first_w  = ((pa_s1 & wm) == '0);
	assign last_w   = ((pa_s1 & wm) == wm);
	assign is_free  = (cur_mark == MARK_FREE);
	assign acc_ok   = first_w ? is_free : (win_ok_q && is_free);
	assign acc_cnt  = (first_w ? '0 : win_cnt_q) + CNT_W'(is_free);
	assign win_base = pa_s1 & ~wm;
	assign scan_found = (state_q == ST_SCAN) && pv_s1 && last_w && acc_ok &&
	                    (scan_mode_q == SCAN_EMPTY);

	assign call_wexp  = in_defrag_q ? cur_sexp_q : piece_exp_q;
	assign call_depth = in_defrag_q ? depth_q + DEPTH_W'(1) : '0;
	assign call_fail  = (call_wexp == 3'd0) || (call_depth >= DEPTH_W'(STACK_DEPTH));

	assign s_slots = CNT_W'(1) << cur_sexp_q;
	assign o_next  = {1'b0, cur_o_q} + s_slots;
	assign win_end = {1'b0, cur_base_q} + (CNT_W'(1) << cur_wexp_q);

	assign piece_bad = (piece_slots == '0) ||
	                   ((piece_slots & (piece_slots - CNT_W'(1))) != '0) ||
	                   (piece_slots > chunk_q);

	always_comb begin
		if (cfg_data == '0) cfg_chunk = CNT_W'(1);
		else if (cfg_data > CNT_W'(MAX_SLOTS)) cfg_chunk = CNT_W'(MAX_SLOTS);
		else cfg_chunk = cfg_data;
	end

	assign free_size = CNT_W'(1) << cur_mark;
	assign free_sum  = {1'b0, free_cnt_q} + {1'b0, free_size};

	always_comb begin
		we_cur = 1'b0;
		we_sav = 1'b0;
		set_v  = 1'b0;
		waddr  = pa_s1;
		wcur   = cur_mark;
		case (state_q)
			ST_FILL: begin
				we_cur = 1'b1;
				waddr  = fill_at_q;
				wcur   = fill_mark_q;
			end
			ST_RESV: begin
				we_cur = pv_s1 && is_free;
				wcur   = MARK_RESV;
			end
			ST_SNAP: begin
				we_cur = pv_s1;
				we_sav = pv_s1;
				set_v  = pv_s1;
			end
			ST_RESTORE: begin
				we_cur = pv_s1;
				wcur   = sav_mark;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_cur) marks_mem[waddr][MARK_W-1:0] <= wcur;
		if (we_sav) marks_mem[waddr][2*MARK_W-1:MARK_W] <= cur_mark;
		mem_rd_q <= marks_mem[raddr];
	end

	assign buf_ctl.clear = req_acc && (req_type == REQ_ALLOC);
	assign buf_ctl.push  = (state_q == ST_MOVE2) && (move_cnt_q != CNT_W'(MAX_MOVES)) &&
	                       report_en_q;
	assign buf_ctl.pop   = (state_q == ST_FLUSH_RD) && !buf_empty;
	assign buf_wr.from   = cur_o_q;
	assign buf_wr.to     = dst_q;
	assign buf_wr.slots  = s_slots[4:0];

	p2sa_move_buf u_move_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (buf_ctl),
		.wr_rec (buf_wr),
		.empty  (buf_empty),
		.rd_rec (buf_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= CNT_W'(MAX_SLOTS);
			report_en_q <= 1'b1;
			free_cnt_q  <= CNT_W'(MAX_SLOTS);
			valid_q     <= '0;
			rd_ok_q     <= 1'b0;
			pv_s1       <= 1'b0;
			ptr_q       <= '0;
			lim_q       <= '0;
			move_cnt_q  <= '0;
			depth_q     <= '0;
			in_defrag_q <= 1'b0;
			rec_valid_q <= 1'b0;
		end else begin
			rd_ok_q <= valid_q[raddr];
			if (set_v) valid_q[waddr] <= 1'b1;

			pa_s1 <= ptr_q[SLOT_W-1:0];
			pv_s1 <= issue;
			if (issue) ptr_q <= ptr_q + CNT_W'(1);

			if (!rec_stall) rec_valid_q <= 1'b0;

			if (state_q == ST_SCAN && pv_s1) begin
				win_ok_q  <= acc_ok;
				win_cnt_q <= acc_cnt;
				if (last_w && scan_mode_q == SCAN_EMPTIER && acc_cnt > best_q) begin
					best_q    <= acc_cnt;
					best_at_q <= win_base;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						if (cfg_index == CFG_CHUNK_SLOTS) begin
							chunk_q    <= cfg_chunk;
							free_cnt_q <= cfg_chunk;
							valid_q    <= '0;
						end else begin
							report_en_q <= cfg_data[0];
						end
					end
					if (req_acc) begin
						piece_q     <= piece_slots;
						piece_exp_q <= exp_of(piece_slots);
						off_q       <= free_offset;
						status_q    <= STAT_OK;
						aoff_q      <= '0;
						in_defrag_q <= 1'b0;
						if (req_type == REQ_FREE) begin
							if ({1'b0, free_offset} >= chunk_q) begin
								status_q <= STAT_BAD_OFFSET;
								state_q  <= ST_RESP;
							end else begin
								state_q <= ST_FREE_CHK;
							end
						end else if (piece_bad) begin
							status_q <= STAT_BAD_SIZE;
							state_q  <= ST_RESP;
						end else if (piece_slots > free_cnt_q) begin
							status_q <= STAT_FULL;
							state_q  <= ST_RESP;
						end else begin
							move_cnt_q <= '0;
							ptr_q      <= '0;
							lim_q      <= CNT_W'(MAX_SLOTS);
							state_q    <= ST_SNAP;
						end
					end
				end
				ST_FREE_CHK: begin
					if (cur_mark == MARK_FREE || cur_mark == MARK_RESV) begin
						status_q <= STAT_NOT_ALLOC;
						state_q  <= ST_RESP;
					end else if (({1'b0, off_q} & (free_size - CNT_W'(1))) != '0) begin
						status_q <= STAT_NOT_START;
						state_q  <= ST_RESP;
					end else begin
						free_cnt_q  <= (free_sum > {1'b0, chunk_q}) ? chunk_q :
						               free_sum[CNT_W-1:0];
						fill_at_q   <= off_q;
						fill_left_q <= free_size;
						fill_mark_q <= MARK_FREE;
						fill_next_q <= ST_RESP;
						state_q     <= ST_FILL;
					end
				end
				ST_FILL: begin
					fill_at_q   <= fill_at_q + SLOT_W'(1);
					fill_left_q <= fill_left_q - CNT_W'(1);
					if (fill_left_q == CNT_W'(1)) state_q <= fill_next_q;
				end
				ST_SNAP: begin
					if (sweep_done) begin
						ptr_q       <= '0;
						lim_q       <= chunk_q & ~mask_of(piece_exp_q);
						scan_wexp_q <= piece_exp_q;
						scan_mode_q <= SCAN_EMPTY;
						best_q      <= '0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_found) begin
						dst_q   <= win_base;
						pv_s1   <= 1'b0;
						state_q <= in_defrag_q ? ST_MOVE : ST_ALLOC_FIN;
					end else if (sweep_done) begin
						if (scan_mode_q == SCAN_EMPTY) begin
							if (call_fail) begin
								ptr_q    <= '0;
								lim_q    <= CNT_W'(MAX_SLOTS);
								status_q <= STAT_DEFRAG_FAIL;
								state_q  <= ST_RESTORE;
							end else begin
								// descend one defrag level, parent frame (if any) onto the stack
								if (in_defrag_q) begin
									defrag_stack_q[depth_q[DEPTH_W-1:0]] <=
										'{base: cur_base_q, wexp: cur_wexp_q,
										  sexp: cur_sexp_q, o: cur_o_q};
								end
								depth_q     <= call_depth;
								in_defrag_q <= 1'b1;
								cur_wexp_q  <= call_wexp;
								ptr_q       <= '0;
								lim_q       <= chunk_q & ~mask_of(call_wexp);
								scan_wexp_q <= call_wexp;
								scan_mode_q <= SCAN_EMPTIER;
								best_q      <= '0;
							end
						end else if (best_q != '0) begin
							cur_base_q <= best_at_q;
							ptr_q      <= {1'b0, best_at_q};
							lim_q      <= {1'b0, best_at_q} + (CNT_W'(1) << cur_wexp_q);
							state_q    <= ST_RESV;
						end else begin
							ptr_q    <= '0;
							lim_q    <= CNT_W'(MAX_SLOTS);
							status_q <= STAT_DEFRAG_FAIL;
							state_q  <= ST_RESTORE;
						end
					end
				end
				ST_RESV: begin
					if (sweep_done) begin
						cur_sexp_q <= cur_wexp_q - 3'd1;
						cur_o_q    <= cur_base_q;
						state_q    <= ST_D_RD;
					end
				end
				ST_D_RD: begin
					state_q <= ST_D_CHK;
				end
				ST_D_CHK: begin
					if (cur_mark == cur_sexp_q) begin
						ptr_q       <= '0;
						lim_q       <= chunk_q & ~mask_of(cur_sexp_q);
						scan_wexp_q <= cur_sexp_q;
						scan_mode_q <= SCAN_EMPTY;
						best_q      <= '0;
						state_q     <= ST_SCAN;
					end else begin
						state_q <= ST_D_NEXT;
					end
				end
				ST_MOVE: begin
					fill_at_q   <= dst_q;
					fill_left_q <= s_slots;
					fill_mark_q <= cur_sexp_q;
					fill_next_q <= ST_MOVE2;
					state_q     <= ST_FILL;
				end
				ST_MOVE2: begin
					if (move_cnt_q == CNT_W'(MAX_MOVES)) begin
						ptr_q    <= '0;
						lim_q    <= CNT_W'(MAX_SLOTS);
						status_q <= STAT_DEFRAG_FAIL;
						state_q  <= ST_RESTORE;
					end else begin
						move_cnt_q  <= move_cnt_q + CNT_W'(1);
						fill_at_q   <= cur_o_q;
						fill_left_q <= s_slots;
						fill_mark_q <= MARK_RESV;
						fill_next_q <= ST_D_NEXT;
						state_q     <= ST_FILL;
					end
				end
				ST_D_NEXT: begin
					if (o_next < win_end) begin
						cur_o_q <= o_next[SLOT_W-1:0];
						state_q <= ST_D_RD;
					end else if (cur_sexp_q != 3'd0) begin
						cur_sexp_q <= cur_sexp_q - 3'd1;
						cur_o_q    <= cur_base_q;
						state_q    <= ST_D_RD;
					end else begin
						// window cleared: hand its base back to the caller
						dst_q <= cur_base_q;
						if (depth_q == '0) begin
							state_q <= ST_ALLOC_FIN;
						end else begin
							cur_base_q <= defrag_stack_q[depth_q - DEPTH_W'(1)].base;
							cur_wexp_q <= defrag_stack_q[depth_q - DEPTH_W'(1)].wexp;
							cur_sexp_q <= defrag_stack_q[depth_q - DEPTH_W'(1)].sexp;
							cur_o_q    <= defrag_stack_q[depth_q - DEPTH_W'(1)].o;
							depth_q    <= depth_q - DEPTH_W'(1);
							state_q    <= ST_MOVE;
						end
					end
				end
				ST_ALLOC_FIN: begin
					in_defrag_q <= 1'b0;
					free_cnt_q  <= free_cnt_q - piece_q;
					aoff_q      <= dst_q;
					fill_at_q   <= dst_q;
					fill_left_q <= piece_q;
					fill_mark_q <= piece_exp_q;
					fill_next_q <= ST_FLUSH_RD;
					state_q     <= ST_FILL;
				end
				ST_RESTORE: begin
					if (sweep_done) begin
						in_defrag_q <= 1'b0;
						state_q     <= ST_RESP;
					end
				end
				ST_FLUSH_RD: begin
					state_q <= buf_empty ? ST_RESP : ST_FLUSH_WAIT;
				end
				ST_FLUSH_WAIT: begin
					if (out_free) begin
						rec_valid_q    <= 1'b1;
						record_kind_q  <= REC_MOVE;
						rec_status_q   <= STAT_OK;
						alloc_offset_q <= '0;
						move_from_q    <= buf_rd.from;
						move_to_q      <= buf_rd.to;
						move_slots_q   <= buf_rd.slots;
						free_left_q    <= '0;
						last_q         <= 1'b0;
						state_q        <= ST_FLUSH_RD;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						rec_valid_q    <= 1'b1;
						record_kind_q  <= REC_FINAL;
						rec_status_q   <= status_q;
						alloc_offset_q <= aoff_q;
						move_from_q    <= '0;
						move_to_q      <= '0;
						move_slots_q   <= '0;
						free_left_q    <= free_cnt_q;
						last_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rec_valid       = rec_valid_q;
	assign record_kind     = record_kind_q;
	assign status          = rec_status_q;
	assign alloc_offset    = alloc_offset_q;
	assign move_from       = move_from_q;
	assign move_to         = move_to_q;
	assign move_slots      = move_slots_q;
	assign free_slots_left = free_left_q;
	assign last            = last_q;

endmodule

// ----- rtl/core/p2sa_checker.sv -----
// port-level checks of the slot allocator, bound to the top level
// depends on p2sa_pkg and pow2_slot_allocator_defrag
module p2sa_port_checker
	import p2sa_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rec_valid,
	input logic              rec_stall,
	input logic              record_kind,
	input logic [2:0]        status,
	input logic [SLOT_W-1:0] alloc_offset,
	input logic [SLOT_W-1:0] move_from,
	input logic [SLOT_W-1:0] move_to,
	input logic [4:0]        move_slots,
	input logic [CNT_W-1:0]  free_slots_left,
	input logic              last
);

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> rec_valid &&
			$stable({record_kind, status, alloc_offset, move_from, move_to,
			         move_slots, free_slots_left, last}))
		else $error("record changed while stalled");

	a_move_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && (record_kind == REC_MOVE) |->
			!last && (free_slots_left == '0) && (status == STAT_OK))
		else $error("malformed move record");

	a_final_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && (record_kind == REC_FINAL) |->
			last && (free_slots_left <= CNT_W'(MAX_SLOTS)))
		else $error("malformed final response");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in progress");

	a_fail_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && (record_kind == REC_FINAL) && (status != STAT_OK) |->
			(alloc_offset == '0))
		else $error("offset reported on a failed request");

endmodule

bind pow2_slot_allocator_defrag p2sa_port_checker u_p2sa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req_valid),
	.req_stall       (req_stall),
	.rec_valid       (rec_valid),
	.rec_stall       (rec_stall),
	.record_kind     (record_kind),
	.status          (status),
	.alloc_offset    (alloc_offset),
	.move_from       (move_from),
	.move_to         (move_to),
	.move_slots      (move_slots),
	.free_slots_left (free_slots_left),
	.last            (last)
);

// ----- verif/p2sa_checker.sv -----
// checker for the slot allocator: watches the request, record and config channels,
// predicts every record and compares it field by field
// depends on p2sa_pkg
`timescale 1ns / 100ps
module p2sa_checker
	import p2sa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  logic              req_type,
	input  logic [CNT_W-1:0]  piece_slots,
	input  logic [SLOT_W-1:0] free_offset,
	input  logic              rec_valid,
	input  logic              rec_stall,
	input  logic              record_kind,
	input  logic [2:0]        status,
	input  logic [SLOT_W-1:0] alloc_offset,
	input  logic [SLOT_W-1:0] move_from,
	input  logic [SLOT_W-1:0] move_to,
	input  logic [4:0]        move_slots,
	input  logic [CNT_W-1:0]  free_slots_left,
	input  logic              last,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [CNT_W-1:0]  cfg_data,
	output int                errors,
	output int                pending
);

	localparam int SLOT_FREE = 255;
	localparam int SLOT_RESV = 254;

	typedef struct {
		logic              kind;
		logic [2:0]        stat;
		logic [SLOT_W-1:0] aoff;
		logic [SLOT_W-1:0] from;
		logic [SLOT_W-1:0] to;
		logic [4:0]        slots;
		logic [CNT_W-1:0]  left;
		logic              fin;
	} alloc_rec_t;

	int         marks [MAX_SLOTS];
	int         chunk;
	bit         report_on;
	int         free_cnt;
	int         moves_done;
	alloc_rec_t move_log[$];
	alloc_rec_t expected_recs[$];

	assign pending = expected_recs.size();

	function automatic void set_marks(int at, int n, int m);
		for (int i = 0; i < n; i++) if (at + i < MAX_SLOTS) marks[at + i] = m;
	endfunction

	function automatic bit first_empty(int w, output int at);
		bit ok;
		at = 0;
		for (int o = 0; o + w <= chunk; o += w) begin
			ok = 1;
			for (int i = 0; i < w; i++) if (marks[o + i] != SLOT_FREE) ok = 0;
			if (ok) begin
				at = o;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic bit emptiest(int w, output int at);
		int cnt;
		int best;
		best = 0;
		at = 0;
		for (int o = 0; o + w <= chunk; o += w) begin
			cnt = 0;
			for (int i = 0; i < w; i++) if (marks[o + i] == SLOT_FREE) cnt++;
			if (cnt > best) begin
				best = cnt;
				at = o;
			end
		end
		return best > 0;
	endfunction

	// clears window w by moving its pieces out, largest first, recursing when stuck
	function automatic bit make_room(int w, output int at, input int depth);
		int base;
		int s;
		int e;
		int dst;
		alloc_rec_t r;
		at = 0;
		if (w < 2 || depth >= STACK_DEPTH) return 0;
		if (!emptiest(w, base)) return 0;
		for (int i = 0; i < w; i++) if (marks[base + i] == SLOT_FREE) marks[base + i] = SLOT_RESV;
		s = w;
		do begin
			s = s / 2;
			e = $clog2(s);
			for (int o = base; o < base + w && o < MAX_SLOTS; o += s) begin
				if (marks[o] != e) continue;
				if (!first_empty(s, dst))
					if (!make_room(s, dst, depth + 1)) return 0;
				set_marks(dst, s, e);
				moves_done++;
				if (moves_done > MAX_MOVES) return 0;
				if (report_on) begin
					r = '{REC_MOVE, STAT_OK, '0, SLOT_W'(o), SLOT_W'(dst), 5'(s), '0, 1'b0};
					move_log.push_back(r);
				end
				set_marks(o, s, SLOT_RESV);
			end
		end while (s > 1);
		at = base;
		return 1;
	endfunction

	function automatic void predict(logic rt, int piece, int off);
		int         saved [MAX_SLOTS];
		logic [2:0] st;
		int         at;
		int         aoff;
		int         m;
		alloc_rec_t r;
		st = STAT_OK;
		aoff = 0;
		at = 0;
		moves_done = 0;
		move_log.delete();
		if (rt == REQ_ALLOC) begin
			if (piece == 0 || (piece & (piece - 1)) != 0 || piece > chunk) st = STAT_BAD_SIZE;
			else if (piece > free_cnt) st = STAT_FULL;
			else begin
				saved = marks;
				if (!first_empty(piece, at) && !make_room(piece, at, 0)) begin
					marks = saved;
					move_log.delete();
					st = STAT_DEFRAG_FAIL;
				end else begin
					free_cnt -= piece;
					set_marks(at, piece, $clog2(piece));
					aoff = at;
				end
			end
		end else if (off >= chunk) st = STAT_BAD_OFFSET;
		else begin
			m = marks[off];
			if (m == SLOT_FREE || m == SLOT_RESV || m > 8) st = STAT_NOT_ALLOC;
			else if ((off & ((1 << m) - 1)) != 0) st = STAT_NOT_START;
			else begin
				set_marks(off, 1 << m, SLOT_FREE);
				free_cnt += 1 << m;
				if (free_cnt > chunk) free_cnt = chunk;
			end
		end
		foreach (move_log[i]) expected_recs.push_back(move_log[i]);
		r = '{REC_FINAL, st, SLOT_W'(aoff), '0, '0, '0, CNT_W'(free_cnt), 1'b1};
		expected_recs.push_back(r);
	endfunction

	task automatic check_field(string name, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_rec_t e;
		int v;
		if (!arst_n) begin
			foreach (marks[i]) marks[i] = SLOT_FREE;
			chunk = MAX_SLOTS;
			report_on = 1;
			free_cnt = MAX_SLOTS;
			errors = 0;
			expected_recs.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CHUNK_SLOTS) begin
					v = cfg_data;
					if (v < 1) v = 1;
					if (v > MAX_SLOTS) v = MAX_SLOTS;
					chunk = v;
					foreach (marks[i]) marks[i] = SLOT_FREE;
					free_cnt = chunk;
				end else begin
					report_on = cfg_data[0];
				end
			end
			if (rec_valid && !rec_stall) begin
				if (expected_recs.size() == 0) begin
					$error("record with nothing expected: kind %0d status %0d", record_kind, status);
					errors++;
				end else begin
					e = expected_recs.pop_front();
					check_field("record_kind", e.kind, record_kind);
					check_field("status", e.stat, status);
					check_field("alloc_offset", e.aoff, alloc_offset);
					check_field("move_from", e.from, move_from);
					check_field("move_to", e.to, move_to);
					check_field("move_slots", e.slots, move_slots);
					check_field("free_slots_left", e.left, free_slots_left);
					check_field("last", e.fin, last);
				end
			end
			// prediction after the compare: records of this item cannot leave in the same cycle
			if (req_valid && !req_stall) predict(req_type, piece_slots, free_offset);
		end
	end

endmodule

// ----- verif/tb.sv -----
// top of the slot allocator testbench: clock, reset, stimulus, stalls and verdict
// depends on p2sa_pkg, pow2_slot_allocator_defrag and p2sa_checker
`timescale 1ns / 100ps
module tb;
	import p2sa_pkg::*;

	localparam int RUN_LIMIT = 40_000_000;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              req_valid = 0;
	logic              req_stall;
	logic              req_type = 0;
	logic [CNT_W-1:0]  piece_slots = 0;
	logic [SLOT_W-1:0] free_offset = 0;
	logic              rec_valid;
	logic              rec_stall = 0;
	logic              record_kind;
	logic [2:0]        status;
	logic [SLOT_W-1:0] alloc_offset;
	logic [SLOT_W-1:0] move_from;
	logic [SLOT_W-1:0] move_to;
	logic [4:0]        move_slots;
	logic [CNT_W-1:0]  free_slots_left;
	logic              last;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	logic              cfg_index = 0;
	logic [CNT_W-1:0]  cfg_data = 0;
	int                errors;
	int                pending;
	int                idle_pct = 0;
	int                stall_pct = 0;
	int                cycles = 0;

	always #5 clk = ~clk;

	pow2_slot_allocator_defrag dut (.*);
	p2sa_checker chk (.*);

	always @(posedge clk) begin
		rec_stall <= ($urandom_range(99) < stall_pct);
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic send_item(logic rt, int piece, int off);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_valid <= 1;
		req_type <= rt;
		piece_slots <= CNT_W'(piece);
		free_offset <= SLOT_W'(off);
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain();
		req_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= CNT_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	// prefers the start of a live piece so that frees mostly succeed
	function automatic int live_offset();
		int o;
		o = $urandom_range(MAX_SLOTS - 1);
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (chk.marks[(o + i) % MAX_SLOTS] <= 5 &&
			    ((o + i) % MAX_SLOTS) % (1 << chk.marks[(o + i) % MAX_SLOTS]) == 0)
				return (o + i) % MAX_SLOTS;
		end
		return o;
	endfunction

	task automatic random_items(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 55) send_item(REQ_ALLOC, 1 << ($urandom_range(99) < 80 ?
				$urandom_range(2) : $urandom_range(5)), $urandom);
			else if (r < 90) send_item(REQ_FREE, $urandom, live_offset());
			else if (r < 95) send_item(REQ_ALLOC, $urandom_range(63), $urandom);
			else send_item(REQ_FREE, $urandom, $urandom_range(31));
		end
	endtask

	initial begin
		int sizes[6];
		sizes = '{32, 8, 0, 63, 16, 7};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// bad sizes, full chunk, wrong start, double free, offset beyond the chunk
		send_item(REQ_ALLOC, 0, 0);
		send_item(REQ_ALLOC, 3, 0);
		send_item(REQ_ALLOC, 63, 0);
		send_item(REQ_ALLOC, 32, 0);
		send_item(REQ_ALLOC, 1, 0);
		send_item(REQ_FREE, 0, 31);
		send_item(REQ_FREE, 0, 0);
		send_item(REQ_FREE, 0, 0);
		write_reg(CFG_CHUNK_SLOTS, 8);
		send_item(REQ_FREE, 0, 9);
		for (int i = 0; i < 8; i++) send_item(REQ_ALLOC, 1, 0);
		for (int i = 1; i < 8; i += 2) send_item(REQ_FREE, 0, i);
		// no aligned pair is free: forces moves
		send_item(REQ_ALLOC, 2, 0);
		send_item(REQ_ALLOC, 2, 0);
		write_reg(CFG_MOVE_REPORT, 0);
		send_item(REQ_FREE, 0, 1);
		send_item(REQ_ALLOC, 4, 0);

		for (int ph = 0; ph < 12; ph++) begin
			write_reg(CFG_CHUNK_SLOTS, sizes[ph % 6]);
			write_reg(CFG_MOVE_REPORT, ph % 3 != 1);
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			random_items(38);
		end
		drain();
		if (errors == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

endmodule
